// ----- hdl/encoder_motion_sequencer_assert.svh -----
// Assertion macros for the encoder motion sequencer checker
`ifndef ENCODER_MOTION_SEQUENCER_ASSERT_SVH
`define ENCODER_MOTION_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define EMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ems assertion failed");

// next-cycle implication
`define EMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ems assertion failed");

`endif

// ----- hdl/ems_pkg.sv -----
// Shared types and constants of the encoder motion sequencer
package ems_pkg;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;
  localparam int TGT_W     = 18;

  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_CM   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_HALF      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_QUARTER   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TURN_PWM    = 4'd3;

  localparam logic [15:0] RST_COUNTS_PER_CM = 16'd2560;
  localparam logic [15:0] RST_TICKS_HALF    = 16'd550;
  localparam logic [15:0] RST_TICKS_QUARTER = 16'd560;
  localparam logic [7:0]  RST_MIN_TURN_PWM  = 8'd40;

  typedef enum logic [3:0] {
    CMD_SAMPLE   = 4'd0,
    CMD_STOP     = 4'd1,
    CMD_FORWARD  = 4'd2,
    CMD_PIVOT_L  = 4'd3,
    CMD_PIVOT_R  = 4'd4,
    CMD_DISTANCE = 4'd5,
    CMD_PIVOT180 = 4'd6,
    CMD_TURN_L90 = 4'd7,
    CMD_TURN_R90 = 4'd8,
    CMD_CLEAR    = 4'd9
  } ems_cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_DIST    = 2'd1,
    MODE_HALF    = 2'd2,
    MODE_QUARTER = 2'd3
  } ems_mode_e;

  typedef struct packed {
    logic [15:0] counts_per_cm_q8;
    logic [15:0] ticks_half_turn;
    logic [15:0] ticks_quarter_turn;
    logic [7:0]  min_turn_pwm;
  } ems_cfg_t;

  typedef struct packed {
    logic [3:0]       command;
    logic             left_pin_a;
    logic             left_pin_b;
    logic             right_pin_a;
    logic             right_pin_b;
    logic [TGT_W-1:0] dist_target;
    logic [7:0]       drive_level;
    logic [7:0]       left_level;
  } ems_item_t;

endpackage

// ----- hdl/ems_if.sv -----
// Channel interfaces: input samples, results and configuration writes
interface ems_item_if;
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic       left_pin_a;
  logic       left_pin_b;
  logic       right_pin_a;
  logic       right_pin_b;
  logic [9:0] travel_cm;
  logic [7:0] drive_level;
  logic [7:0] left_level;

  modport source (output valid, command, left_pin_a, left_pin_b, right_pin_a, right_pin_b,
                  travel_cm, drive_level, left_level, input ready);
  modport sink (input valid, command, left_pin_a, left_pin_b, right_pin_a, right_pin_b,
                travel_cm, drive_level, left_level, output ready);
endinterface

interface ems_result_if;
  logic               valid;
  logic               ready;
  logic [7:0]         right_fwd_pwm;
  logic [7:0]         right_rev_pwm;
  logic [7:0]         left_fwd_pwm;
  logic [7:0]         left_rev_pwm;
  logic               busy_res;
  logic               finished;
  logic signed [31:0] left_position;
  logic signed [31:0] right_position;

  modport source (output valid, right_fwd_pwm, right_rev_pwm, left_fwd_pwm, left_rev_pwm,
                  busy_res, finished, left_position, right_position, input ready);
  modport sink (input valid, right_fwd_pwm, right_rev_pwm, left_fwd_pwm, left_rev_pwm,
                busy_res, finished, left_position, right_position, output ready);
endinterface

interface ems_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/ems_cfg_regs.sv -----
// Configuration register bank
module ems_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  ems_cfg_if.sink        cfg_i,
  output ems_pkg::ems_cfg_t cfg_o
);
  import ems_pkg::*;

  ems_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_COUNTS_PER_CM: cfg_d.counts_per_cm_q8   = cfg_i.data;
        REG_TICKS_HALF:    cfg_d.ticks_half_turn    = cfg_i.data;
        REG_TICKS_QUARTER: cfg_d.ticks_quarter_turn = cfg_i.data;
        REG_MIN_TURN_PWM:  cfg_d.min_turn_pwm       = cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.counts_per_cm_q8   <= RST_COUNTS_PER_CM;
      cfg_q.ticks_half_turn    <= RST_TICKS_HALF;
      cfg_q.ticks_quarter_turn <= RST_TICKS_QUARTER;
      cfg_q.min_turn_pwm       <= RST_MIN_TURN_PWM;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ----- hdl/ems_in_stage.sv -----
// Input register; converts the distance to a count target on the way in
module ems_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  ems_item_if.sink           item_i,
  input  logic [15:0]        counts_per_cm_i,
  input  logic               advance_i,
  output logic               valid_o,
  output ems_pkg::ems_item_t item_o
);
  import ems_pkg::*;

  logic            valid_q, valid_d;
  ems_item_t       item_q, item_d;
  logic [25:0]     dist_prod;
  logic            take;

  assign item_i.ready = !valid_q || advance_i;
  assign take         = item_i.valid && item_i.ready;

  // Q8.8 counts per cm, drop the fraction
  assign dist_prod = 26'(item_i.travel_cm) * 26'(counts_per_cm_i);

  always_comb begin
    item_d.command     = item_i.command;
    item_d.left_pin_a  = item_i.left_pin_a;
    item_d.left_pin_b  = item_i.left_pin_b;
    item_d.right_pin_a = item_i.right_pin_a;
    item_d.right_pin_b = item_i.right_pin_b;
    item_d.dist_target = dist_prod[25:8];
    item_d.drive_level = item_i.drive_level;
    item_d.left_level  = item_i.left_level;
    valid_d = take ? 1'b1 : (advance_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// ----- hdl/ems_core.sv -----
// Counters, move state and result register
module ems_core #(
  parameter int COUNT_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  ems_pkg::ems_item_t item_i,
  input  ems_pkg::ems_cfg_t  cfg_i,
  output logic               advance_o,
  ems_result_if.source       result_o
);
  import ems_pkg::*;

  localparam int CMP_W = (COUNT_BITS > TGT_W) ? COUNT_BITS : TGT_W;
  localparam int EXT_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  logic [COUNT_BITS-1:0] cnt_l_q, cnt_l_d, cnt_r_q, cnt_r_d;
  logic                  prev_l_q, prev_r_q;
  ems_mode_e             mode_q, mode_d;
  logic [TGT_W-1:0]      tgt_q, tgt_d;
  logic [7:0]            rf_q, rf_d, rr_q, rr_d, lf_q, lf_d, lr_q, lr_d;
  logic                  fin_q, fin_d;
  logic                  out_valid_q, out_valid_d;
  logic                  fire;

  logic [7:0]            lvl, clamp;
  logic [COUNT_BITS-1:0] mag_l, mag_r, avg;
  logic                  l_hit, r_hit, avg_hit, done;
  logic [EXT_W-1:0]      ext_l, ext_r;

  assign advance_o   = !out_valid_q || result_o.ready;
  assign fire        = valid_i && advance_o;
  assign out_valid_d = fire ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);

  always_comb begin
    cnt_l_d = cnt_l_q;
    cnt_r_d = cnt_r_q;
    mode_d  = mode_q;
    tgt_d   = tgt_q;
    rf_d    = rf_q;
    rr_d    = rr_q;
    lf_d    = lf_q;
    lr_d    = lr_q;
    fin_d   = 1'b0;
    done    = 1'b0;
    lvl     = item_i.drive_level;
    clamp   = (lvl < cfg_i.min_turn_pwm) ? cfg_i.min_turn_pwm : lvl;

    unique case (ems_cmd_e'(item_i.command))
      CMD_STOP: begin
        {rf_d, rr_d, lf_d, lr_d} = '0;
        mode_d = MODE_IDLE;
      end
      CMD_FORWARD: begin
        {rf_d, rr_d, lf_d, lr_d} = {lvl, 8'd0, 8'd0, item_i.left_level};
        mode_d = MODE_IDLE;
      end
      CMD_PIVOT_L: begin
        {rf_d, rr_d, lf_d, lr_d} = {lvl, 8'd0, lvl, 8'd0};
        mode_d = MODE_IDLE;
      end
      CMD_PIVOT_R: begin
        {rf_d, rr_d, lf_d, lr_d} = {8'd0, lvl, 8'd0, lvl};
        mode_d = MODE_IDLE;
      end
      CMD_DISTANCE: begin
        {cnt_l_d, cnt_r_d} = '0;
        mode_d = MODE_DIST;
        tgt_d  = item_i.dist_target;
        {rf_d, rr_d, lf_d, lr_d} = {lvl, 8'd0, 8'd0, lvl};
      end
      CMD_PIVOT180: begin
        {cnt_l_d, cnt_r_d} = '0;
        mode_d = MODE_HALF;
        tgt_d  = TGT_W'(cfg_i.ticks_half_turn);
        {rf_d, rr_d, lf_d, lr_d} = {8'd0, lvl, 8'd0, lvl};
      end
      CMD_TURN_L90: begin
        {cnt_l_d, cnt_r_d} = '0;
        mode_d = MODE_QUARTER;
        tgt_d  = TGT_W'(cfg_i.ticks_quarter_turn);
        {rf_d, rr_d, lf_d, lr_d} = {clamp, 8'd0, 8'd0, 8'd0};
      end
      CMD_TURN_R90: begin
        {cnt_l_d, cnt_r_d} = '0;
        mode_d = MODE_QUARTER;
        tgt_d  = TGT_W'(cfg_i.ticks_quarter_turn);
        {rf_d, rr_d, lf_d, lr_d} = {8'd0, 8'd0, 8'd0, clamp};
      end
      CMD_CLEAR: {cnt_l_d, cnt_r_d} = '0;
      default: ;
    endcase

    if (item_i.left_pin_a != prev_l_q) begin
      cnt_l_d = (item_i.left_pin_a == item_i.left_pin_b) ?
                cnt_l_d + COUNT_BITS'(1) : cnt_l_d - COUNT_BITS'(1);
    end
    if (item_i.right_pin_a != prev_r_q) begin
      cnt_r_d = (item_i.right_pin_a == item_i.right_pin_b) ?
                cnt_r_d - COUNT_BITS'(1) : cnt_r_d + COUNT_BITS'(1);
    end

    // most negative count reads as 2^(COUNT_BITS-1) unsigned
    mag_l   = cnt_l_d[COUNT_BITS-1] ? COUNT_BITS'(0) - cnt_l_d : cnt_l_d;
    mag_r   = cnt_r_d[COUNT_BITS-1] ? COUNT_BITS'(0) - cnt_r_d : cnt_r_d;
    avg     = (mag_l >> 1) + (mag_r >> 1) + COUNT_BITS'(mag_l[0] & mag_r[0]);
    l_hit   = CMP_W'(mag_l) >= CMP_W'(tgt_d);
    r_hit   = CMP_W'(mag_r) >= CMP_W'(tgt_d);
    avg_hit = CMP_W'(avg) >= CMP_W'(tgt_d);

    case (mode_d)
      MODE_DIST: done = avg_hit;
      MODE_HALF: begin
        if (l_hit) begin
          lf_d = 8'd0;
          lr_d = 8'd0;
        end
        if (r_hit) begin
          rf_d = 8'd0;
          rr_d = 8'd0;
        end
        done = l_hit && r_hit;
      end
      MODE_QUARTER: done = l_hit || r_hit;
      default: done = 1'b0;
    endcase

    if (done) begin
      {rf_d, rr_d, lf_d, lr_d} = '0;
      mode_d = MODE_IDLE;
      fin_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_l_q     <= '0;
      cnt_r_q     <= '0;
      prev_l_q    <= 1'b1;
      prev_r_q    <= 1'b1;
      mode_q      <= MODE_IDLE;
      tgt_q       <= '0;
      rf_q        <= '0;
      rr_q        <= '0;
      lf_q        <= '0;
      lr_q        <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        cnt_l_q  <= cnt_l_d;
        cnt_r_q  <= cnt_r_d;
        prev_l_q <= item_i.left_pin_a;
        prev_r_q <= item_i.right_pin_a;
        mode_q   <= mode_d;
        tgt_q    <= tgt_d;
        rf_q     <= rf_d;
        rr_q     <= rr_d;
        lf_q     <= lf_d;
        lr_q     <= lr_d;
        fin_q    <= fin_d;
      end
    end
  end

  // state only moves when a result is loaded, so it doubles as the result register
  assign ext_l = EXT_W'($signed(cnt_l_q));
  assign ext_r = EXT_W'($signed(cnt_r_q));

  assign result_o.valid          = out_valid_q;
  assign result_o.right_fwd_pwm  = rf_q;
  assign result_o.right_rev_pwm  = rr_q;
  assign result_o.left_fwd_pwm   = lf_q;
  assign result_o.left_rev_pwm   = lr_q;
  assign result_o.busy_res       = (mode_q != MODE_IDLE);
  assign result_o.finished       = fin_q;
  assign result_o.left_position  = ext_l[31:0];
  assign result_o.right_position = ext_r[31:0];
endmodule

// ----- hdl/encoder_motion_sequencer.sv -----
// Encoder motion sequencer top level
// Path: an input transfer is registered in the input register, then in the result register.
// Throughput: one sample per cycle while results are taken; the input register refills while a result waits.
// Stalls: input ready drops only while both registers are full and the result is held.
// Reset: asynchronous, active low; counters zero, previous A levels high, duties zero,
// no move running, configuration registers at their defaults. No clearing pass.
module encoder_motion_sequencer #(
  parameter int COUNT_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ems_item_if.sink     item_i,
  ems_result_if.source result_o,
  ems_cfg_if.sink      cfg_i
);
  import ems_pkg::*;

  ems_cfg_t  cfg;
  ems_item_t item;
  logic      item_valid;
  logic      advance;

  ems_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ems_in_stage u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item_i),
    .counts_per_cm_i (cfg.counts_per_cm_q8),
    .advance_i       (advance),
    .valid_o         (item_valid),
    .item_o          (item)
  );

  ems_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (item_valid),
    .item_i    (item),
    .cfg_i     (cfg),
    .advance_o (advance),
    .result_o  (result_o)
  );
endmodule

// ----- hdl/ems_checker.sv -----
// Port-level checker for the encoder motion sequencer, bound to the top level
`include "encoder_motion_sequencer_assert.svh"

module ems_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       busy_i,
  input logic       finished_i,
  input logic [7:0] rf_i,
  input logic [7:0] rr_i,
  input logic [7:0] lf_i,
  input logic [7:0] lr_i
);
  `EMS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `EMS_ASSERT_NOW(a_fin_idle, out_valid_i && finished_i, !busy_i && (rf_i | rr_i | lf_i | lr_i) == 8'd0)
  `EMS_ASSERT_NOW(a_stall_cause, !in_ready_i, out_valid_i && !out_ready_i)
endmodule

bind encoder_motion_sequencer ems_port_checker u_ems_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .busy_i      (result_o.busy_res),
  .finished_i  (result_o.finished),
  .rf_i        (result_o.right_fwd_pwm),
  .rr_i        (result_o.right_rev_pwm),
  .lf_i        (result_o.left_fwd_pwm),
  .lr_i        (result_o.left_rev_pwm)
);
